@@ src/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd4;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd255;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_BYTE  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_START_A    = 5'd1,
    PH_START_B    = 5'd2,
    PH_START_C    = 5'd3,
    PH_TX_LOW     = 5'd4,
    PH_TX_HIGH    = 5'd5,
    PH_ACK_LOW    = 5'd6,
    PH_ACK_HIGH   = 5'd7,
    PH_ACK_WAIT   = 5'd8,
    PH_ACK_END    = 5'd9,
    PH_WAIT_BYTE  = 5'd10,
    PH_RX_HIGH    = 5'd11,
    PH_RX_LOW     = 5'd12,
    PH_MACK_SETUP = 5'd13,
    PH_MACK_HIGH  = 5'd14,
    PH_MACK_LOW   = 5'd15,
    PH_STOP_A     = 5'd16,
    PH_STOP_B     = 5'd17,
    PH_STOP_C     = 5'd18
  } phase_t;

  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  device_address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_level;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_output_enable;
    logic       busy_res;
    logic       need_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic       status;
  } res_t;

endpackage

@@ src/i2cm_core.sv @@
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer state and one-tick step: next state and line levels.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  i2cm_pkg::cfg_t  cfg,
  input  i2cm_pkg::item_t item,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  delay_r, delay_nxt;
  logic [7:0]  timeout_r, timeout_nxt;
  logic        is_read_r, is_read_nxt;
  logic        status_r, status_nxt;
  logic        rvalid, done;
  logic [7:0]  rdata;
  logic [3:0]  bit_cnt_inc;
  logic [7:0]  rx_shift;

  assign bit_cnt_inc = bit_cnt_r + 4'd1;
  assign rx_shift    = {shift_r[6:0], item.sda_level};

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    delay_nxt      = delay_r;
    timeout_nxt    = timeout_r;
    is_read_nxt    = is_read_r;
    status_nxt     = status_r;
    rvalid         = 1'b0;
    rdata          = 8'd0;
    done           = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (item.operation == OP_WRITE || item.operation == OP_READ) begin
        shift_nxt      = item.device_address;
        bytes_left_nxt = item.byte_count;
        is_read_nxt    = (item.operation == OP_READ);
        status_nxt     = 1'b0;
        bit_cnt_nxt    = 4'd0;
        phase_nxt      = PH_START_A;
        delay_nxt      = cfg.half_period_ticks;
      end
    end else if (phase_r == PH_WAIT_BYTE) begin
      if (item.operation == OP_BYTE) begin
        shift_nxt      = item.write_byte;
        bytes_left_nxt = bytes_left_r - 16'd1;
        bit_cnt_nxt    = 4'd0;
        phase_nxt      = PH_TX_LOW;
        delay_nxt      = cfg.half_period_ticks;
      end
    end else if (phase_r == PH_ACK_WAIT) begin
      if (!item.sda_level) begin
        phase_nxt = PH_ACK_END;
        delay_nxt = cfg.half_period_ticks;
      end else if (timeout_r <= 8'd1) begin
        status_nxt = 1'b1;
        phase_nxt  = PH_STOP_A;
        delay_nxt  = cfg.half_period_ticks;
      end else begin
        timeout_nxt = timeout_r - 8'd1;
      end
    end else if (delay_r > 8'd1) begin
      delay_nxt = delay_r - 8'd1;
    end else begin
      delay_nxt = cfg.half_period_ticks;
      case (phase_r)
        PH_START_A: phase_nxt = PH_START_B;
        PH_START_B: phase_nxt = PH_START_C;
        PH_START_C: phase_nxt = PH_TX_LOW;
        PH_TX_LOW:  phase_nxt = PH_TX_HIGH;
        PH_TX_HIGH: begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_inc;
          phase_nxt   = (bit_cnt_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
        end
        PH_ACK_LOW: phase_nxt = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          phase_nxt   = PH_ACK_WAIT;
          delay_nxt   = delay_r;
          timeout_nxt = cfg.ack_timeout;
        end
        PH_ACK_END: begin
          if (bytes_left_r == 16'd0) begin
            phase_nxt = PH_STOP_A;
          end else if (is_read_r) begin
            bit_cnt_nxt = 4'd0;
            shift_nxt   = 8'd0;
            phase_nxt   = PH_RX_HIGH;
          end else begin
            phase_nxt = PH_WAIT_BYTE;
          end
        end
        PH_RX_HIGH: begin
          shift_nxt   = rx_shift;
          bit_cnt_nxt = bit_cnt_inc;
          if (bit_cnt_inc >= 4'd8) begin
            rvalid         = 1'b1;
            rdata          = rx_shift;
            bytes_left_nxt = bytes_left_r - 16'd1;
          end
          phase_nxt = PH_RX_LOW;
        end
        PH_RX_LOW:     phase_nxt = (bit_cnt_r >= 4'd8) ? PH_MACK_SETUP : PH_RX_HIGH;
        PH_MACK_SETUP: phase_nxt = PH_MACK_HIGH;
        PH_MACK_HIGH:  phase_nxt = PH_MACK_LOW;
        PH_MACK_LOW: begin
          if (bytes_left_r == 16'd0) begin
            phase_nxt = PH_STOP_A;
          end else begin
            bit_cnt_nxt = 4'd0;
            shift_nxt   = 8'd0;
            phase_nxt   = PH_RX_HIGH;
          end
        end
        PH_STOP_A: phase_nxt = PH_STOP_B;
        PH_STOP_B: phase_nxt = PH_STOP_C;
        PH_STOP_C: begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          delay_nxt = 8'd0;
        end
        default: begin
          phase_nxt = PH_IDLE;
          delay_nxt = 8'd0;
        end
      endcase
    end
  end

  // line levels and flags from the state after this tick
  always_comb begin
    logic last_byte;
    last_byte             = (bytes_left_nxt == 16'd0);
    res                   = '0;
    res.scl_level         = 1'b0;
    res.sda_drive         = 1'b1;
    res.sda_output_enable = 1'b1;
    case (phase_nxt)
      PH_IDLE: begin
        res.scl_level         = 1'b1;
        res.sda_output_enable = 1'b0;
      end
      PH_START_A: res.scl_level = 1'b1;
      PH_START_B: begin
        res.scl_level = 1'b1;
        res.sda_drive = 1'b0;
      end
      PH_START_C: res.sda_drive = 1'b0;
      PH_TX_LOW:  res.sda_drive = shift_nxt[7];
      PH_TX_HIGH: begin
        res.scl_level = 1'b1;
        res.sda_drive = shift_nxt[7];
      end
      PH_ACK_LOW, PH_ACK_END, PH_RX_LOW: res.sda_output_enable = 1'b0;
      PH_ACK_HIGH, PH_ACK_WAIT, PH_RX_HIGH: begin
        res.scl_level         = 1'b1;
        res.sda_output_enable = 1'b0;
      end
      PH_WAIT_BYTE: res.sda_drive = 1'b0;
      // nack on the last byte, ack otherwise
      PH_MACK_SETUP, PH_MACK_LOW: res.sda_drive = last_byte;
      PH_MACK_HIGH: begin
        res.scl_level = 1'b1;
        res.sda_drive = last_byte;
      end
      PH_STOP_A: res.sda_drive = 1'b0;
      PH_STOP_B: begin
        res.scl_level = 1'b1;
        res.sda_drive = 1'b0;
      end
      PH_STOP_C: res.scl_level = 1'b1;
      default: begin
        res.scl_level         = 1'b1;
        res.sda_output_enable = 1'b0;
      end
    endcase
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.need_byte  = (phase_nxt == PH_WAIT_BYTE);
    res.read_valid = rvalid;
    res.read_data  = rdata;
    res.done_res   = done;
    res.status     = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 16'd0;
      delay_r      <= 8'd0;
      timeout_r    <= 8'd0;
      is_read_r    <= 1'b0;
      status_r     <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      delay_r      <= delay_nxt;
      timeout_r    <= timeout_nxt;
      is_read_r    <= is_read_nxt;
      status_r     <= status_nxt;
    end
  end

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(bytes_left_r) && $stable(shift_r))
    else $error("sequencer state moved without a tick");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter beyond one byte");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && done |=> phase_r == PH_IDLE)
    else $error("transfer finished but sequencer not idle");

  a_rvalid_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    step && rvalid |-> is_read_r && phase_r == PH_RX_HIGH)
    else $error("read byte outside a read transfer");

endmodule

@@ src/i2c_master_transfer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transfer
// I2C master transfer sequencer with stream in/out and a config write port.
// ----------------------------------------------------------------------------
// Each input word is one bus tick and yields exactly one output word with the
// SCL/SDA levels and transfer flags for that tick. Sustained rate is one word
// per clock while out_tready does not stall the output; a result word passes
// through the input register, then the result register, which is loaded by the
// same edge that steps the state.
// The bus timing is counted in words, not clocks: every timed bus phase lasts
// half_period_ticks words (at least one), and the ACK wait gives up after ack_timeout words.
// Write the config registers only while no transfer is in progress.
module i2c_master_transfer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] operation, [9:2] device_address, [25:10] byte_count,
  // [33:26] write_byte, [34] sda_level, [39:35] zero
  input  logic [i2cm_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] scl_level, [1] sda_drive, [2] sda_output_enable, [3] busy_res,
  // [4] need_byte, [5] read_valid, [13:6] read_data, [14] done_res, [15] status
  output logic [i2cm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import i2cm_pkg::*;

  cfg_t  cfg_r;
  item_t item_r;
  logic  in_valid_r;
  res_t  res;
  res_t  out_res_r;
  logic  out_valid_r;
  logic  advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_PERIOD_RST;
      cfg_r.ack_timeout       <= ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_IDX_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_wdata;
        CFG_IDX_ACK_TIMEOUT: cfg_r.ack_timeout       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.operation      <= op_t'(in_tdata[1:0]);
      item_r.device_address <= in_tdata[9:2];
      item_r.byte_count     <= in_tdata[25:10];
      item_r.write_byte     <= in_tdata[33:26];
      item_r.sda_level      <= in_tdata[34];
    end
  end

  i2cm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cfg   (cfg_r),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.status, out_res_r.done_res, out_res_r.read_data,
                       out_res_r.read_valid, out_res_r.need_byte, out_res_r.busy_res,
                       out_res_r.sda_output_enable, out_res_r.sda_drive,
                       out_res_r.scl_level};

endmodule

@@ test/i2c_master_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_checker
// Watches the stream channels and the config port of the i2c master, predicts
// the bus levels and flags of every accepted tick and compares each result
// word against the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_master_checker
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // [1:0] operation, [9:2] device_address, [25:10] byte_count,
  // [33:26] write_byte, [34] sda_level, [39:35] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] scl_level, [1] sda_drive, [2] sda_output_enable, [3] busy_res,
  // [4] need_byte, [5] read_valid, [13:6] read_data, [14] done_res, [15] status
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending,
  output phase_t                bus_phase
);

  typedef struct packed {
    phase_t      ph;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] left;
    logic [7:0]  dly;
    logic [7:0]  tmo;
    logic        rd;
    logic        nack;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        done;
  } seq_t;

  seq_t seq;
  cfg_t cfg;
  res_t levels_q[$];
  int   fails = 0;

  assign errors = fails;

  // one bus tick of the sequencer
  function automatic seq_t advance(seq_t s, item_t it, cfg_t c);
    phase_t nxt;
    logic   reload;
    nxt        = s.ph;
    reload     = 1'b0;
    s.rx_valid = 1'b0;
    s.rx_byte  = 8'h00;
    s.done     = 1'b0;
    case (s.ph)
      PH_IDLE: begin
        if (it.operation == OP_WRITE || it.operation == OP_READ) begin
          s.shreg   = it.device_address;
          s.left    = it.byte_count;
          s.rd      = (it.operation == OP_READ);
          s.nack    = 1'b0;
          s.bit_cnt = 4'd0;
          nxt       = PH_START_A;
          reload    = 1'b1;
        end
      end
      PH_WAIT_BYTE: begin
        if (it.operation == OP_BYTE) begin
          s.shreg   = it.write_byte;
          s.left    = s.left - 16'd1;
          s.bit_cnt = 4'd0;
          nxt       = PH_TX_LOW;
          reload    = 1'b1;
        end
      end
      PH_ACK_WAIT: begin
        if (!it.sda_level) begin
          nxt    = PH_ACK_END;
          reload = 1'b1;
        end else if (s.tmo <= 8'd1) begin
          s.nack = 1'b1;
          nxt    = PH_STOP_A;
          reload = 1'b1;
        end else begin
          s.tmo = s.tmo - 8'd1;
        end
      end
      default: begin
        if (s.dly > 8'd1) begin
          s.dly = s.dly - 8'd1;
        end else begin
          reload = 1'b1;
          case (s.ph)
            PH_START_A:    nxt = PH_START_B;
            PH_START_B:    nxt = PH_START_C;
            PH_START_C:    nxt = PH_TX_LOW;
            PH_TX_LOW:     nxt = PH_TX_HIGH;
            PH_TX_HIGH: begin
              s.shreg   = s.shreg << 1;
              s.bit_cnt = s.bit_cnt + 4'd1;
              nxt       = (s.bit_cnt >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
            end
            PH_ACK_LOW:    nxt = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
              // the ack wait runs on the timeout counter, delay is left as is
              nxt    = PH_ACK_WAIT;
              reload = 1'b0;
              s.tmo  = c.ack_timeout;
            end
            PH_ACK_END: begin
              if (s.left == 16'd0) begin
                nxt = PH_STOP_A;
              end else if (s.rd) begin
                s.bit_cnt = 4'd0;
                s.shreg   = 8'h00;
                nxt       = PH_RX_HIGH;
              end else begin
                nxt = PH_WAIT_BYTE;
              end
            end
            PH_RX_HIGH: begin
              s.shreg   = {s.shreg[6:0], it.sda_level};
              s.bit_cnt = s.bit_cnt + 4'd1;
              if (s.bit_cnt >= 4'd8) begin
                s.rx_valid = 1'b1;
                s.rx_byte  = s.shreg;
                s.left     = s.left - 16'd1;
              end
              nxt = PH_RX_LOW;
            end
            PH_RX_LOW:     nxt = (s.bit_cnt >= 4'd8) ? PH_MACK_SETUP : PH_RX_HIGH;
            PH_MACK_SETUP: nxt = PH_MACK_HIGH;
            PH_MACK_HIGH:  nxt = PH_MACK_LOW;
            PH_MACK_LOW: begin
              if (s.left == 16'd0) begin
                nxt = PH_STOP_A;
              end else begin
                s.bit_cnt = 4'd0;
                s.shreg   = 8'h00;
                nxt       = PH_RX_HIGH;
              end
            end
            PH_STOP_A:     nxt = PH_STOP_B;
            PH_STOP_B:     nxt = PH_STOP_C;
            PH_STOP_C: begin
              s.done = 1'b1;
              nxt    = PH_IDLE;
              reload = 1'b0;
              s.dly  = 8'd0;
            end
            default: begin
              nxt    = PH_IDLE;
              reload = 1'b0;
              s.dly  = 8'd0;
            end
          endcase
        end
      end
    endcase
    s.ph = nxt;
    if (reload) s.dly = c.half_period_ticks;
    return s;
  endfunction

  // line levels and flags seen after a tick
  function automatic res_t bus_levels(seq_t s);
    res_t r;
    r                   = '0;
    r.sda_drive         = 1'b1;
    r.sda_output_enable = 1'b1;
    case (s.ph)
      PH_IDLE: begin
        r.scl_level         = 1'b1;
        r.sda_output_enable = 1'b0;
      end
      PH_START_A:   r.scl_level = 1'b1;
      PH_START_B: begin
        r.scl_level = 1'b1;
        r.sda_drive = 1'b0;
      end
      PH_START_C:   r.sda_drive = 1'b0;
      PH_TX_LOW:    r.sda_drive = s.shreg[7];
      PH_TX_HIGH: begin
        r.scl_level = 1'b1;
        r.sda_drive = s.shreg[7];
      end
      PH_ACK_LOW, PH_ACK_END, PH_RX_LOW: r.sda_output_enable = 1'b0;
      PH_ACK_HIGH, PH_ACK_WAIT, PH_RX_HIGH: begin
        r.scl_level         = 1'b1;
        r.sda_output_enable = 1'b0;
      end
      PH_WAIT_BYTE: r.sda_drive = 1'b0;
      // nack only on the last read byte
      PH_MACK_SETUP, PH_MACK_LOW: r.sda_drive = (s.left == 16'd0);
      PH_MACK_HIGH: begin
        r.scl_level = 1'b1;
        r.sda_drive = (s.left == 16'd0);
      end
      PH_STOP_A:    r.sda_drive = 1'b0;
      PH_STOP_B: begin
        r.scl_level = 1'b1;
        r.sda_drive = 1'b0;
      end
      PH_STOP_C:    r.scl_level = 1'b1;
      default: begin
        r.scl_level         = 1'b1;
        r.sda_output_enable = 1'b0;
      end
    endcase
    r.busy_res   = (s.ph != PH_IDLE);
    r.need_byte  = (s.ph == PH_WAIT_BYTE);
    r.read_valid = s.rx_valid;
    r.read_data  = s.rx_byte;
    r.done_res   = s.done;
    r.status     = s.nack;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    seq_t  nxt_seq;
    item_t it;
    res_t  want;
    res_t  got;
    cfg_t  c;
    if (!rst_n) begin
      seq                   <= '0;
      cfg.half_period_ticks <= HALF_PERIOD_RST;
      cfg.ack_timeout       <= ACK_TIMEOUT_RST;
      levels_q.delete();
      pending               <= 0;
      bus_phase             <= PH_IDLE;
    end else begin
      c = cfg;
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_IDX_HALF_PERIOD) c.half_period_ticks = cfg_wdata;
        else if (cfg_addr == CFG_IDX_ACK_TIMEOUT) c.ack_timeout = cfg_wdata;
      end
      cfg <= c;

      if (out_tvalid && out_tready) begin
        got.scl_level         = out_tdata[0];
        got.sda_drive         = out_tdata[1];
        got.sda_output_enable = out_tdata[2];
        got.busy_res          = out_tdata[3];
        got.need_byte         = out_tdata[4];
        got.read_valid        = out_tdata[5];
        got.read_data         = out_tdata[13:6];
        got.done_res          = out_tdata[14];
        got.status            = out_tdata[15];
        if (levels_q.size() == 0) begin
          $error("result word 0x%0h with no expectation waiting", out_tdata);
          fails++;
        end else begin
          want = levels_q.pop_front();
          check_field("scl_level", 32'(want.scl_level), 32'(got.scl_level));
          check_field("sda_drive", 32'(want.sda_drive), 32'(got.sda_drive));
          check_field("sda_output_enable", 32'(want.sda_output_enable),
                      32'(got.sda_output_enable));
          check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
          check_field("need_byte", 32'(want.need_byte), 32'(got.need_byte));
          check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
          check_field("read_data", 32'(want.read_data), 32'(got.read_data));
          check_field("done_res", 32'(want.done_res), 32'(got.done_res));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end

      nxt_seq = seq;
      if (in_tvalid && in_tready) begin
        it.operation      = op_t'(in_tdata[1:0]);
        it.device_address = in_tdata[9:2];
        it.byte_count     = in_tdata[25:10];
        it.write_byte     = in_tdata[33:26];
        it.sda_level      = in_tdata[34];
        nxt_seq           = advance(seq, it, cfg);
        levels_q.push_back(bus_levels(nxt_seq));
      end
      seq       <= nxt_seq;
      bus_phase <= nxt_seq.ph;
      pending   <= levels_q.size();
    end
  end

endmodule

@@ test/tb_i2c_master_transfer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer
// Drives bus ticks into the i2c master: directed write and read transfers
// first, then random transfers over several bus rates and ack timeouts with
// slave acks, refusals and stray commands, with random idling on both sides in the earlier phases.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer;
  import i2cm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ALL_ACKED   = 255;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES   = 1;
  localparam int FILL_ZEROS  = 2;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = CFG_IDX_HALF_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int     errors;
  int     pending;
  phase_t bus_phase;
  int     snd_idle   = 15;
  int     rcv_idle   = 52;
  int     words_sent = 0;
  int     stall_cnt  = 0;
  logic   slow_bus   = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  i2c_master_transfer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  i2c_master_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .bus_phase  (bus_phase)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // present one tick word and hold it until taken
  task automatic send_word(op_t op, logic [7:0] addr, logic [15:0] count,
                           logic [7:0] wb, logic sda);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, sda, wb, count, addr, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // stop sending and wait for every predicted word to come out
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] half_period, logic [7:0] ack_tmo);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_IDX_HALF_PERIOD;
    cfg_wdata <= half_period;
    @(posedge clk);
    cfg_addr  <= CFG_IDX_ACK_TIMEOUT;
    cfg_wdata <= ack_tmo;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slow_bus = (half_period > 8'd8);
  endtask

  // one transfer from the begin command until the bus is back to idle;
  // acks gives how many ack slots the slave answers before it refuses
  task automatic run_xfer(op_t cmd, logic [7:0] addr, logic [15:0] count,
                          int acks, bit noisy, int fill);
    phase_t ph;
    phase_t prev_ph;
    op_t    op;
    int     ack_idx;
    int     pick;
    bit     seen_busy;
    bit     finished;
    logic   sda;
    logic [7:0] wb;
    prev_ph   = PH_IDLE;
    ack_idx   = 0;
    seen_busy = 1'b0;
    finished  = 1'b0;
    send_word(cmd, addr, count, 8'($urandom), 1'($urandom_range(1)));
    while (!finished) begin
      // the phase seen here trails the word just taken by one tick
      ph = bus_phase;
      if (prev_ph == PH_ACK_WAIT && ph != PH_ACK_WAIT) ack_idx++;
      prev_ph = ph;
      if (ph != PH_IDLE) seen_busy = 1'b1;
      if (seen_busy && ph == PH_IDLE) begin
        finished = 1'b1;
      end else begin
        op = OP_TICK;
        if (ph == PH_WAIT_BYTE) begin
          if ($urandom_range(3) != 0) op = OP_BYTE;
          else if (noisy) op = $urandom_range(1) ? OP_WRITE : OP_READ;
        end else if (noisy && $urandom_range(5) == 0 &&
                     !(ph inside {PH_IDLE, PH_STOP_A, PH_STOP_B, PH_STOP_C})) begin
          pick = $urandom_range(2);
          op   = (pick == 0) ? OP_WRITE : (pick == 1) ? OP_READ : OP_BYTE;
        end
        if (fill == FILL_ONES) wb = 8'hFF;
        else if (fill == FILL_ZEROS) wb = 8'h00;
        else wb = 8'($urandom);
        if (ph inside {PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_WAIT})
          sda = (ack_idx < acks) ? ($urandom_range(3) == 0) : 1'b1;
        else if (ph inside {PH_RX_HIGH, PH_RX_LOW} && fill != FILL_RANDOM)
          sda = (fill == FILL_ONES);
        else
          sda = 1'($urandom_range(1));
        send_word(op, 8'($urandom), 16'($urandom), wb, sda);
      end
    end
  endtask

  task automatic random_xfer();
    op_t         cmd;
    int          kind;
    int          acks;
    logic [15:0] count;
    cmd  = $urandom_range(1) ? OP_WRITE : OP_READ;
    kind = $urandom_range(9);
    if (kind == 0) begin
      // long count, cut short by the slave
      count = 16'($urandom);
      acks  = (cmd == OP_WRITE) ? $urandom_range(3) : 0;
    end else begin
      count = slow_bus ? 16'($urandom_range(1)) : 16'($urandom_range(6));
      acks  = (kind == 1) ? $urandom_range(count) : ALL_ACKED;
    end
    run_xfer(cmd, 8'($urandom), count, acks, $urandom_range(3) == 0, FILL_RANDOM);
    repeat ($urandom_range(2))
      send_word($urandom_range(1) ? OP_TICK : OP_BYTE, 8'($urandom), 16'($urandom),
                8'($urandom), 1'($urandom_range(1)));
    if ($urandom_range(11) == 0) settle();
  endtask

  task automatic run_phase(logic [7:0] half_period, logic [7:0] ack_tmo, int words);
    int target;
    set_config(half_period, ack_tmo);
    target = words_sent + words;
    while (words_sent < target) random_xfer();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // an idle tick and a stray byte before any transfer
    send_word(OP_TICK, 8'h00, 16'h0000, 8'h00, 1'b0);
    send_word(OP_BYTE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    run_xfer(OP_WRITE, 8'h00, 16'd0, ALL_ACKED, 1'b0, FILL_RANDOM);
    // fast bus and a short ack wait for the directed transfers
    set_config(8'd1, 8'd20);
    run_xfer(OP_WRITE, 8'hFF, 16'd2, ALL_ACKED, 1'b0, FILL_ONES);
    run_xfer(OP_WRITE, 8'h5A, 16'd3, ALL_ACKED, 1'b1, FILL_ZEROS);
    run_xfer(OP_READ, 8'hA5, 16'd3, ALL_ACKED, 1'b0, FILL_ONES);
    run_xfer(OP_READ, 8'h01, 16'd1, ALL_ACKED, 1'b1, FILL_ZEROS);
    run_xfer(OP_READ, 8'h80, 16'd0, ALL_ACKED, 1'b0, FILL_RANDOM);
    // slave never answers the address
    run_xfer(OP_WRITE, 8'h7F, 16'hFFFF, 0, 1'b0, FILL_RANDOM);
    run_xfer(OP_READ, 8'hC3, 16'hFFFF, 0, 1'b1, FILL_RANDOM);
    // refused on the second data byte
    run_xfer(OP_WRITE, 8'h3C, 16'd3, 2, 1'b1, FILL_RANDOM);
    send_word(OP_BYTE, 8'h00, 16'h8000, 8'h80, 1'b0);

    run_phase(8'd1, 8'd1, 80);
    run_phase(8'd0, 8'd0, 60);
    snd_idle = 52;
    rcv_idle = 15;
    run_phase(8'd2, 8'd6, 100);
    snd_idle = 0;
    rcv_idle = 0;
    run_phase(8'd1, 8'd255, 100);
    run_phase(8'd3, 8'd2, 60);

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
